[rtl/svps_pkg.sv]
// Shared types and constants for the servo pulse sequencer.
`default_nettype none
package svps_pkg;

	localparam int NUM_CH = 6;
	localparam int CH_W   = 3;
	localparam int WID_W  = 12;
	localparam int ANG_W  = 10;
	localparam int SPAN_W = 10;
	localparam int DIFF_W = WID_W + 1;
	localparam int PROD_W = ANG_W + DIFF_W;
	localparam int MAG_W  = PROD_W - 1;
	localparam int CNT_W  = 5;
	localparam int REV_W  = WID_W + 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CH_W-1:0]  NUM_CH_C  = NUM_CH[CH_W-1:0];
	localparam logic [CNT_W-1:0] DIV_LAST  = MAG_W[CNT_W-1:0] - 5'd1;
	localparam logic [WID_W-1:0] WIDTH_MAX = {WID_W{1'b1}};

	localparam logic [WID_W-1:0]  RST_MIN_WIDTH    = 12'd50;
	localparam logic [WID_W-1:0]  RST_MAX_WIDTH    = 12'd250;
	localparam logic [WID_W-1:0]  RST_CENTER_WIDTH = 12'd150;
	localparam logic [SPAN_W-1:0] RST_ANGLE_SPAN   = 10'd180;
	localparam logic [CH_W-1:0]   RST_CHANNEL_CNT  = 3'd6;

	typedef enum logic [2:0] {
		CMD_SET_WIDTH = 3'd0,
		CMD_SET_ANGLE = 3'd1,
		CMD_INC       = 3'd2,
		CMD_DEC       = 3'd3,
		CMD_RESET_ALL = 3'd4,
		CMD_START     = 3'd5,
		CMD_TICK      = 3'd6
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_WIDTH    = 3'd0,
		REG_MAX_WIDTH    = 3'd1,
		REG_CENTER_WIDTH = 3'd2,
		REG_ANGLE_SPAN   = 3'd3,
		REG_CHANNEL_CNT  = 3'd4,
		REG_REVERSE_MASK = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ABS,
		ST_DIV,
		ST_ANGLE,
		ST_SCAN,
		ST_RESULT
	} state_t;

endpackage
`default_nettype wire

[rtl/servo_pulse_sequencer.sv]
// Servo pulse sequencer: per-channel width store, angle converter and frame sequencer.
//
// Takes one command item at a time and returns one status item (pin levels, frame
// active, frame done) per command. Set width, inc, dec, reset all, a tick that only
// counts down and ignored commands go from the execute state to the result state. Set
// angle on a valid channel runs one multiply, a magnitude step, then a restoring divider
// that produces one quotient bit per cycle, then an offset and saturation step. Start,
// and a tick that ends a pulse, scan the channels through one shared pulse-length unit
// at one channel per cycle. The input side is ready only while the sequencer is idle; a
// finished result sits in the output register while the next item is accepted.
// Configuration writes are always taken.
`default_nettype none
module servo_pulse_sequencer (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [2:0]                           command,
	input  wire logic [svps_pkg::CH_W-1:0]            channel,
	input  wire logic [svps_pkg::WID_W-1:0]           width,
	input  wire logic signed [svps_pkg::ANG_W-1:0]    angle,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [svps_pkg::NUM_CH-1:0]               pin_mask,
	output logic                                      frame_active,
	output logic                                      frame_done,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [svps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [svps_pkg::CFG_DATA_W-1:0]      cfg_data
);

	svps_pkg::state_t state_q, state_d;

	// configuration
	logic [svps_pkg::WID_W-1:0]  min_q, max_q, center_q;
	logic [svps_pkg::SPAN_W-1:0] span_q;
	logic [svps_pkg::CH_W-1:0]   chcnt_q;
	logic [svps_pkg::NUM_CH-1:0] rev_q;

	// channel state
	logic [svps_pkg::WID_W-1:0] widths_q [svps_pkg::NUM_CH];
	logic                       running_q;
	logic [svps_pkg::CH_W-1:0]  cur_q;
	logic [svps_pkg::WID_W-1:0] ticks_q;
	logic                       done_q;

	// latched item
	svps_pkg::cmd_t                  cmd_q;
	logic [svps_pkg::CH_W-1:0]       ch_q;
	logic [svps_pkg::WID_W-1:0]      wid_q;
	logic signed [svps_pkg::ANG_W-1:0] ang_q;

	// angle datapath
	logic signed [svps_pkg::PROD_W-1:0] prod_q;
	logic [svps_pkg::MAG_W-1:0]         dvd_q;
	logic [svps_pkg::SPAN_W-1:0]        rem_q;
	logic                               neg_q;
	logic [svps_pkg::CNT_W-1:0]         div_cnt_q;
	logic [svps_pkg::CH_W-1:0]          scan_q;

	// result register
	logic                        out_valid_q;
	logic [svps_pkg::NUM_CH-1:0] pin_q;
	logic                        active_q;
	logic                        fdone_q;

	logic                        in_acc;
	logic                        ch_ok;
	logic [svps_pkg::CH_W-1:0]   n_active;
	logic [svps_pkg::CH_W-1:0]   rd_idx;
	logic [svps_pkg::WID_W-1:0]  rd_w;
	logic signed [svps_pkg::DIFF_W-1:0] diff_s;
	logic signed [svps_pkg::PROD_W-1:0] prod_c;
	logic signed [svps_pkg::PROD_W-1:0] prod_neg;
	logic [svps_pkg::SPAN_W-1:0]        span_eff;
	logic [svps_pkg::SPAN_W:0]          trial;
	logic [svps_pkg::SPAN_W:0]          trial_sub;
	logic                               trial_ge;
	logic signed [svps_pkg::PROD_W-1:0] quo_s;
	logic signed [svps_pkg::PROD_W:0]   ang_sum;
	logic [svps_pkg::WID_W-1:0]         ang_w;
	logic signed [svps_pkg::REV_W-1:0]  rev_s;
	logic [svps_pkg::WID_W-1:0]         len_c;
	logic                               scan_end;

	assign in_acc   = in_valid && in_ready;
	assign ch_ok    = ch_q < svps_pkg::NUM_CH_C;
	assign n_active = (chcnt_q > svps_pkg::NUM_CH_C) ? svps_pkg::NUM_CH_C : chcnt_q;
	assign scan_end = scan_q >= n_active;

	always_comb begin
		if (state_q == svps_pkg::ST_SCAN) begin
			rd_idx = scan_end ? '0 : scan_q;
		end else begin
			rd_idx = ch_ok ? ch_q : '0;
		end
	end
	assign rd_w = widths_q[rd_idx];

	// angle * (max - min)
	assign diff_s   = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
	assign prod_c   = ang_q * diff_s;
	assign prod_neg = -prod_q;
	assign span_eff = (span_q == '0) ? {{(svps_pkg::SPAN_W-1){1'b0}}, 1'b1} : span_q;

	// shared restoring divide step
	assign trial     = {rem_q, dvd_q[svps_pkg::MAG_W-1]};
	assign trial_ge  = trial >= {1'b0, span_eff};
	assign trial_sub = trial - {1'b0, span_eff};

	// quotient sign, center offset, saturation
	assign quo_s   = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
	assign ang_sum = $signed({quo_s[svps_pkg::PROD_W-1], quo_s})
		+ $signed({{(svps_pkg::PROD_W+1-svps_pkg::WID_W){1'b0}}, center_q});
	always_comb begin
		if (ang_sum < 0) begin
			ang_w = '0;
		end else if (ang_sum > $signed({{(svps_pkg::PROD_W+1-svps_pkg::WID_W){1'b0}},
				svps_pkg::WIDTH_MAX})) begin
			ang_w = svps_pkg::WIDTH_MAX;
		end else begin
			ang_w = ang_sum[svps_pkg::WID_W-1:0];
		end
	end

	// pulse length of the scanned channel, reversed as max - w + min
	assign rev_s = $signed({2'b00, max_q}) + $signed({2'b00, min_q})
		- $signed({2'b00, rd_w});
	always_comb begin
		if (!rev_q[rd_idx]) begin
			len_c = rd_w;
		end else if (rev_s < 0) begin
			len_c = '0;
		end else if (rev_s > $signed({2'b00, svps_pkg::WIDTH_MAX})) begin
			len_c = svps_pkg::WIDTH_MAX;
		end else begin
			len_c = rev_s[svps_pkg::WID_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			svps_pkg::ST_IDLE: begin
				if (in_acc) state_d = svps_pkg::ST_EXEC;
			end
			svps_pkg::ST_EXEC: begin
				state_d = svps_pkg::ST_RESULT;
				case (cmd_q)
					svps_pkg::CMD_SET_ANGLE: begin
						if (ch_ok) state_d = svps_pkg::ST_ABS;
					end
					svps_pkg::CMD_START: begin
						if (!running_q) state_d = svps_pkg::ST_SCAN;
					end
					svps_pkg::CMD_TICK: begin
						if (running_q && ticks_q <= 12'd1) state_d = svps_pkg::ST_SCAN;
					end
					default: state_d = svps_pkg::ST_RESULT;
				endcase
			end
			svps_pkg::ST_ABS: state_d = svps_pkg::ST_DIV;
			svps_pkg::ST_DIV: begin
				if (div_cnt_q == svps_pkg::DIV_LAST) state_d = svps_pkg::ST_ANGLE;
			end
			svps_pkg::ST_ANGLE: state_d = svps_pkg::ST_RESULT;
			svps_pkg::ST_SCAN: begin
				if (scan_end || len_c != '0) state_d = svps_pkg::ST_RESULT;
			end
			svps_pkg::ST_RESULT: begin
				if (!out_valid_q || out_ready) state_d = svps_pkg::ST_IDLE;
			end
			default: state_d = svps_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready  = (state_q == svps_pkg::ST_IDLE);
		cfg_ready = 1'b1;
	end

	assign out_valid    = out_valid_q;
	assign pin_mask     = pin_q;
	assign frame_active = active_q;
	assign frame_done   = fdone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= svps_pkg::RST_MIN_WIDTH;
			max_q    <= svps_pkg::RST_MAX_WIDTH;
			center_q <= svps_pkg::RST_CENTER_WIDTH;
			span_q   <= svps_pkg::RST_ANGLE_SPAN;
			chcnt_q  <= svps_pkg::RST_CHANNEL_CNT;
			rev_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (svps_pkg::reg_idx_t'(cfg_index))
				svps_pkg::REG_MIN_WIDTH:    min_q    <= cfg_data[svps_pkg::WID_W-1:0];
				svps_pkg::REG_MAX_WIDTH:    max_q    <= cfg_data[svps_pkg::WID_W-1:0];
				svps_pkg::REG_CENTER_WIDTH: center_q <= cfg_data[svps_pkg::WID_W-1:0];
				svps_pkg::REG_ANGLE_SPAN:   span_q   <= cfg_data[svps_pkg::SPAN_W-1:0];
				svps_pkg::REG_CHANNEL_CNT:  chcnt_q  <= cfg_data[svps_pkg::CH_W-1:0];
				svps_pkg::REG_REVERSE_MASK: rev_q    <= cfg_data[svps_pkg::NUM_CH-1:0];
				default: ;
			endcase
		end
	end

	// item latch, arithmetic payload and result fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= svps_pkg::cmd_t'(command);
			ch_q  <= channel;
			wid_q <= width;
			ang_q <= angle;
		end
		if (state_q == svps_pkg::ST_EXEC) begin
			prod_q <= prod_c;
		end
		if (state_q == svps_pkg::ST_ABS) begin
			neg_q <= prod_q[svps_pkg::PROD_W-1];
			dvd_q <= prod_q[svps_pkg::PROD_W-1] ? prod_neg[svps_pkg::MAG_W-1:0]
				: prod_q[svps_pkg::MAG_W-1:0];
			rem_q <= '0;
		end else if (state_q == svps_pkg::ST_DIV) begin
			rem_q <= trial_ge ? trial_sub[svps_pkg::SPAN_W-1:0] : trial[svps_pkg::SPAN_W-1:0];
			dvd_q <= {dvd_q[svps_pkg::MAG_W-2:0], trial_ge};
		end
		if (state_q == svps_pkg::ST_RESULT && (!out_valid_q || out_ready)) begin
			pin_q    <= running_q ? ({{(svps_pkg::NUM_CH-1){1'b0}}, 1'b1} << cur_q) : '0;
			active_q <= running_q;
			fdone_q  <= done_q;
		end
	end

	// channel widths, frame state, sequencer counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < svps_pkg::NUM_CH; i++) widths_q[i] <= '0;
			running_q   <= 1'b0;
			cur_q       <= '0;
			ticks_q     <= '0;
			done_q      <= 1'b0;
			scan_q      <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				svps_pkg::ST_EXEC: begin
					done_q    <= 1'b0;
					div_cnt_q <= '0;
					case (cmd_q)
						svps_pkg::CMD_SET_WIDTH: begin
							if (ch_ok) widths_q[rd_idx] <= wid_q;
						end
						svps_pkg::CMD_INC: begin
							if (ch_ok && ({1'b0, rd_w} + 13'd1) <= {1'b0, max_q})
								widths_q[rd_idx] <= rd_w + 12'd1;
						end
						svps_pkg::CMD_DEC: begin
							if (ch_ok && rd_w > min_q) widths_q[rd_idx] <= rd_w - 12'd1;
						end
						svps_pkg::CMD_RESET_ALL: begin
							for (int i = 0; i < svps_pkg::NUM_CH; i++) begin
								if (i < int'(n_active)) widths_q[i] <= center_q;
							end
						end
						svps_pkg::CMD_START: begin
							scan_q <= '0;
						end
						svps_pkg::CMD_TICK: begin
							if (running_q && ticks_q > 12'd1) ticks_q <= ticks_q - 12'd1;
							scan_q <= cur_q + 3'd1;
						end
						default: ;
					endcase
				end
				svps_pkg::ST_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
				end
				svps_pkg::ST_ANGLE: begin
					widths_q[rd_idx] <= ang_w;
				end
				svps_pkg::ST_SCAN: begin
					if (scan_end) begin
						running_q <= 1'b0;
						cur_q     <= '0;
						ticks_q   <= '0;
						done_q    <= (cmd_q == svps_pkg::CMD_TICK);
					end else if (len_c != '0) begin
						running_q <= 1'b1;
						cur_q     <= scan_q;
						ticks_q   <= len_c;
					end else begin
						scan_q <= scan_q + 3'd1;
					end
				end
				default: ;
			endcase
			if (state_q == svps_pkg::ST_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_run_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (ticks_q != '0 && cur_q < svps_pkg::NUM_CH_C))
		else $error("running frame without a loaded pulse");

	a_pin_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_active) |-> $onehot(pin_mask))
		else $error("active frame result without exactly one pin");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_done) |-> (!frame_active && pin_mask == '0))
		else $error("frame done while still pulsing");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == svps_pkg::ST_ANGLE) |-> ($past(state_q) == svps_pkg::ST_DIV
			&& $past(div_cnt_q) == svps_pkg::DIV_LAST))
		else $error("divider finished early");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted while previous still in work");
`endif

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the servo pulse sequencer: command stimulus, status prediction.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import svps_pkg::*;

	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [NUM_CH-1:0] pins;
		logic              active;
		logic              done;
	} servo_status_t;

	// Tracks widths and frame progress, predicts one status item per command.
	class servo_status_board;
		logic [WID_W-1:0]  min_w, max_w, center_w;
		logic [SPAN_W-1:0] span;
		logic [CH_W-1:0]   count;
		logic [NUM_CH-1:0] rev;
		logic [WID_W-1:0]  widths[NUM_CH];
		bit                running;
		int                cur;
		int                left;
		servo_status_t     pending[$];
		int                errors;
		int                commands;
		int                checked;
		int                frames;

		function new();
			min_w    = RST_MIN_WIDTH;
			max_w    = RST_MAX_WIDTH;
			center_w = RST_CENTER_WIDTH;
			span     = RST_ANGLE_SPAN;
			count    = RST_CHANNEL_CNT;
			rev      = '0;
			foreach (widths[i]) widths[i] = '0;
			running  = 0;
			cur      = 0;
			left     = 0;
			errors   = 0;
			commands = 0;
			checked  = 0;
			frames   = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_MIN_WIDTH:    min_w    = d[WID_W-1:0];
				REG_MAX_WIDTH:    max_w    = d[WID_W-1:0];
				REG_CENTER_WIDTH: center_w = d[WID_W-1:0];
				REG_ANGLE_SPAN:   span     = d[SPAN_W-1:0];
				REG_CHANNEL_CNT:  count    = d[CH_W-1:0];
				REG_REVERSE_MASK: rev      = d[NUM_CH-1:0];
				default: ;
			endcase
		endfunction

		function int pulse_ticks(int ch);
			int w;
			w = int'(widths[ch]);
			if (rev[ch]) begin
				w = int'(max_w) - w + int'(min_w);
				if (w < 0) w = 0;
				if (w > 4095) w = 4095;
			end
			return w;
		endfunction

		// first channel at or after 'from' with a nonzero pulse starts; else the frame ends
		function bit load_pulse(int from);
			int n;
			n = (int'(count) > NUM_CH) ? NUM_CH : int'(count);
			for (int ch = from; ch < n; ch++) begin
				if (pulse_ticks(ch) != 0) begin
					cur = ch;
					left = pulse_ticks(ch);
					running = 1;
					return 1;
				end
			end
			running = 0;
			cur = 0;
			left = 0;
			return 0;
		endfunction

		function logic [WID_W-1:0] angle_width(logic signed [ANG_W-1:0] a);
			int div;
			int diff;
			int p;
			div = (span == 0) ? 1 : int'(span);
			diff = int'(max_w) - int'(min_w);
			p = int'(a) * diff / div + int'(center_w);
			if (p < 0) p = 0;
			if (p > 4095) p = 4095;
			return p[WID_W-1:0];
		endfunction

		function void note_command(logic [2:0] cmd, logic [CH_W-1:0] ch, logic [WID_W-1:0] w,
				logic signed [ANG_W-1:0] a);
			bit ch_ok;
			bit done;
			int n;
			servo_status_t st;
			ch_ok = int'(ch) < NUM_CH;
			done = 0;
			commands++;
			case (cmd)
				CMD_SET_WIDTH: if (ch_ok) widths[ch] = w;
				CMD_SET_ANGLE: if (ch_ok) widths[ch] = angle_width(a);
				CMD_INC: if (ch_ok && int'(widths[ch]) + 1 <= int'(max_w))
					widths[ch] = widths[ch] + 1'b1;
				CMD_DEC: if (ch_ok && int'(widths[ch]) - 1 >= int'(min_w))
					widths[ch] = widths[ch] - 1'b1;
				CMD_RESET_ALL: begin
					n = (int'(count) > NUM_CH) ? NUM_CH : int'(count);
					for (int i = 0; i < n; i++) widths[i] = center_w;
				end
				CMD_START: if (!running) void'(load_pulse(0));
				CMD_TICK: if (running) begin
					if (left > 1) left--;
					else if (!load_pulse(cur + 1)) done = 1;
				end
				default: ;
			endcase
			st.pins = running ? (NUM_CH'(1) << cur) : '0;
			st.active = running;
			st.done = done;
			pending.push_back(st);
		endfunction

		function void check_status(logic [NUM_CH-1:0] pins, logic active, logic done);
			servo_status_t exp_st;
			if (pending.size() == 0) begin
				$display("%0t: status item with none expected: pins %h active %b done %b",
					$time, pins, active, done);
				errors++;
				return;
			end
			exp_st = pending.pop_front();
			checked++;
			if (done === 1'b1) frames++;
			if (pins !== exp_st.pins) begin
				$display("%0t: pin_mask expected %h actual %h", $time, exp_st.pins, pins);
				errors++;
			end
			if (active !== exp_st.active) begin
				$display("%0t: frame_active expected %b actual %b", $time, exp_st.active, active);
				errors++;
			end
			if (done !== exp_st.done) begin
				$display("%0t: frame_done expected %b actual %b", $time, exp_st.done, done);
				errors++;
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [2:0]               command;
	logic [CH_W-1:0]          channel;
	logic [WID_W-1:0]         width;
	logic signed [ANG_W-1:0]  angle;
	logic                     out_valid;
	logic                     out_ready;
	logic [NUM_CH-1:0]        pin_mask;
	logic                     frame_active;
	logic                     frame_done;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;

	servo_status_board board = new();
	bit quiet_in;
	bit quiet_out;
	int settings;
	int idle_cycles;

	servo_pulse_sequencer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.channel      (channel),
		.width        (width),
		.angle        (angle),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pin_mask     (pin_mask),
		.frame_active (frame_active),
		.frame_done   (frame_done),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid && out_ready) board.check_status(pin_mask, frame_active, frame_done);
		if (in_valid && in_ready) board.note_command(command, channel, width, angle);
		if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: random stall per item, with stall-free stretches
	initial begin
		int hold;
		int taken;
		out_ready = 1'b0;
		taken = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (taken % 50 == 0) quiet_out = ($urandom_range(0, 3) == 0);
			hold = quiet_out ? 0 : $urandom_range(0, 5);
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	task automatic send_command(input logic [2:0] cmd, input logic [CH_W-1:0] ch,
			input logic [WID_W-1:0] w, input logic signed [ANG_W-1:0] a);
		int gap;
		gap = quiet_in ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command  <= cmd;
		channel  <= ch;
		width    <= w;
		angle    <= a;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_regs(input int mn, input int mx, input int ctr, input int spn,
			input int cnt, input int rmask);
		cfg_write(REG_MIN_WIDTH, CFG_DATA_W'(mn));
		cfg_write(REG_MAX_WIDTH, CFG_DATA_W'(mx));
		cfg_write(REG_CENTER_WIDTH, CFG_DATA_W'(ctr));
		cfg_write(REG_ANGLE_SPAN, CFG_DATA_W'(spn));
		cfg_write(REG_CHANNEL_CNT, CFG_DATA_W'(cnt));
		cfg_write(REG_REVERSE_MASK, CFG_DATA_W'(rmask));
		settings++;
	endtask

	// frame traffic most often; unused fields carry random bits
	task automatic random_command();
		int r;
		logic [2:0]        cmd;
		logic [CH_W-1:0]   ch;
		logic [WID_W-1:0]  w;
		logic [ANG_W-1:0]  a;
		r = $urandom_range(0, 99);
		ch = ($urandom_range(0, 9) != 0) ? CH_W'($urandom_range(0, NUM_CH - 1)) :
			CH_W'($urandom_range(NUM_CH, 7));
		w = WID_W'($urandom);
		a = ANG_W'($urandom);
		if (r < 40)      cmd = CMD_TICK;
		else if (r < 48) cmd = CMD_START;
		else if (r < 62) cmd = CMD_SET_WIDTH;
		else if (r < 72) cmd = CMD_SET_ANGLE;
		else if (r < 80) cmd = CMD_INC;
		else if (r < 88) cmd = CMD_DEC;
		else if (r < 93) cmd = CMD_RESET_ALL;
		else if (r < 96) cmd = CMD_UNUSED;
		else             cmd = 3'($urandom);
		// keep stored widths short so frames finish; full range only on ignored channels
		if (cmd == CMD_SET_WIDTH && int'(ch) < NUM_CH) w = WID_W'($urandom_range(0, 24));
		send_command(cmd, ch, w, a);
	endtask

	initial begin
		int mn;
		int mx;
		int spn;
		in_valid  = 1'b0;
		command   = CMD_SET_WIDTH;
		channel   = '0;
		width     = '0;
		angle     = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_MIN_WIDTH;
		cfg_data  = '0;
		quiet_in  = 0;
		quiet_out = 0;
		settings  = 0;
		idle_cycles = 0;
		arst_n    = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset settings: idle tick, empty frame, unused code, field extremes, limits
		send_command(CMD_TICK, 3'd0, 12'hfff, 10'sd0);
		send_command(CMD_START, 3'd7, 12'h000, -10'sd512);
		send_command(CMD_UNUSED, 3'd3, 12'h5a5, 10'sd511);
		send_command(CMD_SET_WIDTH, 3'd0, 12'hfff, 10'sd0);
		send_command(CMD_SET_WIDTH, 3'd6, 12'd100, 10'sd0);
		send_command(CMD_SET_ANGLE, 3'd7, 12'd0, 10'sd90);
		send_command(CMD_SET_ANGLE, 3'd2, 12'd0, 10'sd511);
		send_command(CMD_SET_ANGLE, 3'd3, 12'd0, -10'sd512);
		send_command(CMD_SET_ANGLE, 3'd4, 12'd0, 10'sd0);
		send_command(CMD_INC, 3'd4, 12'd0, 10'sd0);
		send_command(CMD_DEC, 3'd3, 12'd0, 10'sd0);
		send_command(CMD_SET_WIDTH, 3'd5, 12'd250, 10'sd0);
		send_command(CMD_INC, 3'd5, 12'd0, 10'sd0);
		send_command(CMD_RESET_ALL, 3'd0, 12'd0, 10'sd0);

		// zero span, oversized count, odd channels reversed
		drain_results();
		program_regs(1, 3, 2, 0, 7, 6'b101010);
		send_command(CMD_RESET_ALL, 3'd0, 12'd0, 10'sd0);
		send_command(CMD_SET_WIDTH, 3'd0, 12'd0, 10'sd0);
		send_command(CMD_SET_ANGLE, 3'd2, 12'd0, -10'sd1);
		send_command(CMD_SET_WIDTH, 3'd3, 12'hfff, 10'sd0);
		send_command(CMD_START, 3'd0, 12'd0, 10'sd0);
		send_command(CMD_START, 3'd0, 12'd0, 10'sd0);
		send_command(CMD_TICK, 3'd0, 12'd0, 10'sd0);
		send_command(CMD_SET_WIDTH, 3'd4, 12'd1, 10'sd0);
		repeat (4) send_command(CMD_TICK, 3'd0, 12'd0, 10'sd0);
		send_command(CMD_RESET_ALL, 3'd0, 12'd0, 10'sd0);

		for (int phase = 0; phase < 8; phase++) begin
			drain_results();
			mn = $urandom_range(0, 6);
			mx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : mn + $urandom_range(0, 14);
			spn = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(200, 1023);
			if (phase == 7) spn = 1023;
			if (spn < 2) mx = mn;
			program_regs(mn, mx, $urandom_range(0, 20), spn, $urandom_range(0, 7), $urandom);
			for (int k = 0; k < 240; k++) begin
				if (k % 60 == 0) quiet_in = ($urandom_range(0, 3) == 0);
				if (k == 120) drain_results();
				random_command();
			end
		end

		// let any running frame finish before the wide settings
		drain_results();
		while (board.running) begin
			send_command(CMD_TICK, CH_W'($urandom), WID_W'($urandom), ANG_W'($urandom));
			drain_results();
		end

		// full-scale span: a positive angle saturates high, a negative one lands mid-range
		program_regs(0, 4095, 4095, 1023, 7, 0);
		send_command(CMD_SET_ANGLE, 3'd1, 12'd0, 10'sd511);
		send_command(CMD_SET_ANGLE, 3'd2, 12'd0, -10'sd512);
		drain_results();

		// reversed length above range clamps to 4095, pulse must not end early
		program_regs(3000, 3000, 2, 700, 1, 6'h3f);
		send_command(CMD_SET_WIDTH, 3'd0, 12'd1000, 10'sd0);
		send_command(CMD_START, 3'd0, 12'd0, 10'sd0);
		for (int k = 0; k < 40; k++) begin
			if (k % 3 == 0) random_command();
			else send_command(CMD_TICK, CH_W'($urandom), WID_W'($urandom), ANG_W'($urandom));
		end

		drain_results();
		repeat (40) @(negedge clk);
		$display("Covered %0d commands under %0d register settings; %0d status items checked.",
			board.commands, settings, board.checked);
		$display("Frames completed: %0d, mismatches: %0d.", board.frames, board.errors);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[servo_pulse_sequencer.f]
rtl/svps_pkg.sv
rtl/servo_pulse_sequencer.sv
sim/tb_top.sv
